### hdl/scatter_gather_list_walker_assert.svh
// Assertion macros shared by the checker of the scatter-gather list walker.
`ifndef SCATTER_GATHER_LIST_WALKER_ASSERT_SVH
`define SCATTER_GATHER_LIST_WALKER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SGLW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scatter_gather_list_walker: check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SGLW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scatter_gather_list_walker: check failed");

`endif

### hdl/sglw_pkg.sv
// Package of the scatter-gather list walker: sizes, codes and control structs.
`default_nettype none

package sglw_pkg;

  localparam int MaxEntries = 16;
  localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int CmdW       = 2;
  localparam int BaseW      = 64;
  localparam int LenW       = 32;
  localparam int SizeW      = 36;
  localparam int EntryW     = BaseW + LenW;

  typedef enum logic [CmdW-1:0] {
    CmdClear  = 2'd0,
    CmdAppend = 2'd1,
    CmdXfer   = 2'd2
  } cmd_e;

  typedef enum logic {
    StIdle,
    StWalk
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic append;
    logic refuse;
    logic empty;
    logic load;
    logic walk;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic clip_zero;
    logic walk_end;
  } dp_sts_t;

endpackage

`default_nettype wire

### hdl/sglw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sglw_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/sglw_ctrl.sv
// Controller state machine of the scatter-gather list walker.
`default_nettype none

module sglw_ctrl import sglw_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire logic [CmdW-1:0] command_i,
  input  wire dp_sts_t         sts_i,
  output logic                 busy,
  output dp_cmd_t              cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          priority case (command_i)
            CmdClear: begin
              cmd_o.clear = 1'b1;
            end
            CmdAppend: begin
              if (sts_i.full) begin
                cmd_o.refuse = 1'b1;
              end else begin
                cmd_o.append = 1'b1;
              end
            end
            CmdXfer: begin
              if (sts_i.clip_zero) begin
                cmd_o.empty = 1'b1;
              end else begin
                cmd_o.load = 1'b1;
                state_d    = StWalk;
              end
            end
            default: begin
              // Unknown commands are dropped without a result.
            end
          endcase
        end
      end
      StWalk: begin
        busy       = 1'b1;
        cmd_o.walk = 1'b1;
        if (sts_i.walk_end) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/sglw_dp.sv
// Datapath of the scatter-gather list walker: entry store, totals and segment math.
`default_nettype none

module sglw_dp import sglw_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dp_cmd_t          cmd_i,
  input  wire logic [BaseW-1:0] entry_base_i,
  input  wire logic [LenW-1:0]  length_i,
  input  wire logic             direction_i,
  output dp_sts_t               sts_o,
  output logic                  result_valid_o,
  output logic                  status_o,
  output logic [BaseW-1:0]      seg_base_o,
  output logic [LenW-1:0]       seg_len_o,
  output logic [SizeW-1:0]      buf_offset_o,
  output logic [SizeW-1:0]      residual_o,
  output logic                  seg_direction_o,
  output logic                  last_o
);

  logic [CntW-1:0]   count_q;
  logic [SizeW-1:0]  total_q;
  logic [SizeW-1:0]  rem_q;
  logic [SizeW-1:0]  resid_q;
  logic [SizeW-1:0]  off_q;
  logic              dir_q;
  logic [IdxW-1:0]   idx_q;

  logic [IdxW-1:0]   idx_inc;
  logic [IdxW-1:0]   raddr;
  logic [EntryW-1:0] rdata;
  logic [BaseW-1:0]  ebase;
  logic [LenW-1:0]   elen;

  logic [SizeW-1:0]  len_ext;
  logic [SizeW-1:0]  clipped;
  logic [SizeW:0]    rem_diff;
  logic              lt;
  logic [LenW-1:0]   xfer;
  logic [SizeW-1:0]  rem_nx;
  logic [SizeW-1:0]  resid_nx;
  logic [SizeW-1:0]  off_nx;
  logic              seg_last;

  logic              valid_q;
  logic              status_q;
  logic [BaseW-1:0]  seg_base_q;
  logic [LenW-1:0]   seg_len_q;
  logic [SizeW-1:0]  buf_offset_q;
  logic [SizeW-1:0]  residual_q;
  logic              seg_dir_q;
  logic              last_q;

  // Read address runs one entry ahead because the store has a registered read.
  assign idx_inc = idx_q + IdxW'(1);
  assign raddr   = cmd_i.load ? '0 : idx_inc;

  sglw_ram #(
    .Width (EntryW),
    .Depth (MaxEntries)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i ({entry_base_i, length_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ebase = rdata[EntryW-1:LenW];
  assign elen  = rdata[LenW-1:0];

  assign len_ext = SizeW'(length_i);
  assign clipped = (len_ext < total_q) ? len_ext : total_q;

  // Both outcomes of the clip are computed side by side and picked by the borrow.
  assign rem_diff = {1'b0, rem_q} - {1'b0, SizeW'(elen)};
  assign lt       = rem_diff[SizeW];
  assign xfer     = lt ? rem_q[LenW-1:0] : elen;
  assign rem_nx   = lt ? '0 : rem_diff[SizeW-1:0];
  assign resid_nx = lt ? (resid_q - rem_q) : (resid_q - SizeW'(elen));
  assign off_nx   = lt ? (off_q + rem_q) : (off_q + SizeW'(elen));
  assign seg_last = (rem_nx == '0);

  assign sts_o.full      = (count_q == CntW'(MaxEntries));
  assign sts_o.clip_zero = (clipped == '0);
  assign sts_o.walk_end  = seg_last || ((CntW'(idx_q) + CntW'(1)) == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
        total_q <= '0;
      end else if (cmd_i.append) begin
        count_q <= count_q + CntW'(1);
        total_q <= total_q + len_ext;
      end
      // A zero-length entry moves no bytes and gives no segment.
      valid_q <= cmd_i.clear || cmd_i.append || cmd_i.refuse || cmd_i.empty ||
                 (cmd_i.walk && (elen != '0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q   <= clipped;
      resid_q <= total_q;
      off_q   <= '0;
      dir_q   <= direction_i;
      idx_q   <= '0;
    end else if (cmd_i.walk) begin
      rem_q   <= rem_nx;
      resid_q <= resid_nx;
      off_q   <= off_nx;
      idx_q   <= idx_inc;
    end

    if (cmd_i.walk) begin
      status_q     <= 1'b0;
      seg_base_q   <= ebase;
      seg_len_q    <= xfer;
      buf_offset_q <= off_q;
      residual_q   <= resid_nx;
      seg_dir_q    <= dir_q;
      last_q       <= seg_last;
    end else begin
      status_q     <= cmd_i.refuse;
      seg_base_q   <= '0;
      seg_len_q    <= '0;
      buf_offset_q <= '0;
      residual_q   <= cmd_i.empty ? total_q : '0;
      seg_dir_q    <= cmd_i.empty ? direction_i : 1'b0;
      last_q       <= 1'b1;
    end
  end

  assign result_valid_o  = valid_q;
  assign status_o        = status_q;
  assign seg_base_o      = seg_base_q;
  assign seg_len_o       = seg_len_q;
  assign buf_offset_o    = buf_offset_q;
  assign residual_o      = residual_q;
  assign seg_direction_o = seg_dir_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

### hdl/scatter_gather_list_walker.sv
// Top level of the scatter-gather list walker: controller plus datapath.
`default_nettype none

// A command is taken on a rising edge with start high and busy low. Each result
// is on the ports for exactly one cycle with result_valid_o high; results cannot
// be held off, so the receiver must take every one. Clear, append, a refused
// append and a transfer that clips to zero bytes each give a single result in
// the next cycle; busy stays low and a new command may follow in the next cycle.
// A transfer of nonzero size raises busy while it walks the list entries, up to
// the entry count, because the entry store gives one entry per cycle through its
// single registered read port. Its first segment is read from the entry store and
// then registered onto the ports, and later entries are walked in turn. Entries
// of zero length are walked but give no segment.
module scatter_gather_list_walker import sglw_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [CmdW-1:0]  command_i,
  input  wire logic [BaseW-1:0] entry_base_i,
  input  wire logic [LenW-1:0]  length_i,
  input  wire logic             direction_i,
  output logic                  result_valid_o,
  output logic                  status_o,
  output logic [BaseW-1:0]      seg_base_o,
  output logic [LenW-1:0]       seg_len_o,
  output logic [SizeW-1:0]      buf_offset_o,
  output logic [SizeW-1:0]      residual_o,
  output logic                  seg_direction_o,
  output logic                  last_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  sglw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .sts_i     (dp_sts),
    .busy      (busy),
    .cmd_o     (dp_cmd)
  );

  sglw_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .entry_base_i    (entry_base_i),
    .length_i        (length_i),
    .direction_i     (direction_i),
    .sts_o           (dp_sts),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .seg_base_o      (seg_base_o),
    .seg_len_o       (seg_len_o),
    .buf_offset_o    (buf_offset_o),
    .residual_o      (residual_o),
    .seg_direction_o (seg_direction_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

### hdl/sglw_checker.sv
// Port-level checker of the scatter-gather list walker and its bind.
`default_nettype none

`include "scatter_gather_list_walker_assert.svh"

module sglw_checker import sglw_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [CmdW-1:0]  command_i,
  input wire logic             result_valid_o,
  input wire logic             status_o,
  input wire logic [LenW-1:0]  seg_len_o,
  input wire logic             last_o
);

  logic take;
  logic unknown_cmd;

  assign take        = start && !busy;
  assign unknown_cmd = !(command_i == CmdClear || command_i == CmdAppend ||
                         command_i == CmdXfer);

  // A clear always answers in the next cycle with a single good result.
  `SGLW_ASSERT_NEXT(a_clear_result, take && (command_i == CmdClear), result_valid_o && last_o && !status_o)
  // An append answers in the next cycle with a single result.
  `SGLW_ASSERT_NEXT(a_append_result, take && (command_i == CmdAppend), result_valid_o && last_o)
  // An unknown command gives no result.
  `SGLW_ASSERT_NEXT(a_unknown_silent, take && unknown_cmd, !result_valid_o)
  // A refusal is a single result that moves no bytes.
  `SGLW_ASSERT_NOW(a_refuse_shape, result_valid_o && status_o, last_o && (seg_len_o == '0))
  // More segments still to come means the walk is still running.
  `SGLW_ASSERT_NOW(a_mid_walk_busy, result_valid_o && !last_o, busy)

endmodule

bind scatter_gather_list_walker sglw_checker u_sglw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .command_i      (command_i),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .seg_len_o      (seg_len_o),
  .last_o         (last_o)
);

`default_nettype wire

### bench/sglw_segment_checker.sv
// Checker for the scatter-gather list walker: predicts each command's results and compares them.
module sglw_segment_checker import sglw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [CmdW-1:0]  command_i,
  input  logic [BaseW-1:0] entry_base_i,
  input  logic [LenW-1:0]  length_i,
  input  logic             direction_i,
  input  logic             result_valid_i,
  input  logic             status_i,
  input  logic [BaseW-1:0] seg_base_i,
  input  logic [LenW-1:0]  seg_len_i,
  input  logic [SizeW-1:0] buf_offset_i,
  input  logic [SizeW-1:0] residual_i,
  input  logic             seg_direction_i,
  input  logic             last_i,
  output int               mismatch_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             status;
    logic [BaseW-1:0] base;
    logic [LenW-1:0]  len;
    logic [SizeW-1:0] offset;
    logic [SizeW-1:0] residual;
    logic             dir;
    logic             last;
  } segment_t;

  logic [BaseW-1:0] list_bases   [MaxEntries];
  logic [LenW-1:0]  list_lengths [MaxEntries];
  int unsigned      list_count;
  logic [SizeW-1:0] list_total;
  segment_t         expected_segments [$];
  int               mismatches;

  task automatic predict_segments(input logic [CmdW-1:0] cmd, input logic [BaseW-1:0] base,
                                  input logic [LenW-1:0] len, input logic dir);
    logic [SizeW-1:0] remaining;
    logic [SizeW-1:0] resid;
    logic [SizeW-1:0] offset;
    logic [SizeW-1:0] amount;
    segment_t         seg;
    seg = '0;
    seg.last = 1'b1;
    case (cmd)
      CmdClear: begin
        list_count = 0;
        list_total = '0;
        expected_segments.push_back(seg);
      end
      CmdAppend: begin
        if (list_count >= MaxEntries) begin
          seg.status = 1'b1;
        end else begin
          list_bases[list_count]   = base;
          list_lengths[list_count] = len;
          list_count++;
          list_total = list_total + SizeW'(len);
        end
        expected_segments.push_back(seg);
      end
      CmdXfer: begin
        remaining = (SizeW'(len) < list_total) ? SizeW'(len) : list_total;
        resid     = list_total;
        offset    = '0;
        seg.dir   = dir;
        if (remaining == '0) begin
          seg.residual = list_total;
          expected_segments.push_back(seg);
        end else begin
          // Zero-length entries are walked past without a segment of their own.
          for (int i = 0; i < list_count && remaining != '0; i++) begin
            amount = (remaining < SizeW'(list_lengths[i])) ? remaining
                                                           : SizeW'(list_lengths[i]);
            if (amount != '0) begin
              remaining    = remaining - amount;
              resid        = resid - amount;
              seg.base     = list_bases[i];
              seg.len      = amount[LenW-1:0];
              seg.offset   = offset;
              seg.residual = resid;
              seg.last     = (remaining == '0);
              expected_segments.push_back(seg);
              offset = offset + amount;
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [BaseW-1:0] want,
                             input logic [BaseW-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    segment_t want;
    if (!rst_ni) begin
      list_count = 0;
      list_total = '0;
      expected_segments.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      // A command's results are registered and come after its transfer, so predicting first is safe.
      if (start_i && !busy_i) begin
        predict_segments(command_i, entry_base_i, length_i, direction_i);
      end
      if (result_valid_i) begin
        if (expected_segments.size() == 0) begin
          mismatches++;
          $display("%0t: no result expected, got base %h len %h last %b",
                   $time, seg_base_i, seg_len_i, last_i);
        end else begin
          want = expected_segments.pop_front();
          check_field("status", want.status, status_i);
          check_field("seg_base", want.base, seg_base_i);
          check_field("seg_len", want.len, seg_len_i);
          check_field("buf_offset", want.offset, buf_offset_i);
          check_field("residual", want.residual, residual_i);
          check_field("seg_direction", want.dir, seg_direction_i);
          check_field("last", want.last, last_i);
        end
      end
      mismatch_count_o <= mismatches;
      pending_o <= expected_segments.size();
    end
  end

endmodule

### bench/testbench.sv
// Top of the scatter-gather list walker bench: clock, reset, command stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sglw_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam int TargetItems = 280;
  localparam int DrainCycles = 24;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic [CmdW-1:0]  command_i = CmdClear;
  logic [BaseW-1:0] entry_base_i = '0;
  logic [LenW-1:0]  length_i = '0;
  logic             direction_i = 1'b0;
  logic             busy;
  logic             result_valid_o;
  logic             status_o;
  logic [BaseW-1:0] seg_base_o;
  logic [LenW-1:0]  seg_len_o;
  logic [SizeW-1:0] buf_offset_o;
  logic [SizeW-1:0] residual_o;
  logic             seg_direction_o;
  logic             last_o;
  int               mismatch_count;
  int               pending;

  // Stimulus-side view of the list, used to aim transfer sizes, and a count of commands issued.
  int               issued = 0;
  int               listed_entries = 0;
  logic [SizeW-1:0] listed_bytes = '0;

  scatter_gather_list_walker uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .entry_base_i    (entry_base_i),
    .length_i        (length_i),
    .direction_i     (direction_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .seg_base_o      (seg_base_o),
    .seg_len_o       (seg_len_o),
    .buf_offset_o    (buf_offset_o),
    .residual_o      (residual_o),
    .seg_direction_o (seg_direction_o),
    .last_o          (last_o)
  );

  sglw_segment_checker segment_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .command_i        (command_i),
    .entry_base_i     (entry_base_i),
    .length_i         (length_i),
    .direction_i      (direction_i),
    .result_valid_i   (result_valid_o),
    .status_i         (status_o),
    .seg_base_i       (seg_base_o),
    .seg_len_i        (seg_len_o),
    .buf_offset_i     (buf_offset_o),
    .residual_i       (residual_o),
    .seg_direction_i  (seg_direction_o),
    .last_i           (last_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Offers one command and returns at the edge where its transfer happens.
  task automatic issue(input logic [CmdW-1:0] cmd, input logic [BaseW-1:0] base,
                       input logic [LenW-1:0] len, input logic dir);
    int idle;
    case ((issued * 4) / TargetItems)
      1: idle = 45;
      3: idle = 16;
      default: idle = 0;
    endcase
    while ($urandom_range(0, 99) < idle) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    command_i    <= cmd;
    entry_base_i <= base;
    length_i     <= len;
    direction_i  <= dir;
    do @(posedge clk_i); while (busy);
    case (cmd)
      CmdClear: begin
        listed_entries = 0;
        listed_bytes   = '0;
      end
      CmdAppend: begin
        if (listed_entries < MaxEntries) begin
          listed_entries++;
          listed_bytes = listed_bytes + SizeW'(len);
        end
      end
      default: begin
      end
    endcase
    if (cmd != CmdUnused) begin
      issued++;
    end
  endtask

  initial begin : stimulus
    int unsigned      pick;
    int unsigned      n_append;
    int unsigned      n_xfer;
    logic [LenW-1:0]  len;
    logic [LenW-1:0]  cap;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Transfer over an empty list, an ignored command, then the field extremes.
    issue(CmdXfer, '1, '1, 1'b1);
    issue(CmdUnused, '1, '1, 1'b1);
    issue(CmdClear, '1, '1, 1'b1);
    issue(CmdAppend, '1, '1, 1'b0);
    issue(CmdAppend, '0, '0, 1'b1);
    issue(CmdAppend, 64'h0123_4567_89ab_cdef, 32'd1, 1'b0);
    issue(CmdXfer, '0, '0, 1'b0);
    issue(CmdXfer, '0, 32'h8000_0000, 1'b1);
    issue(CmdXfer, '1, '1, 1'b0);
    // Fill the list to capacity; the append after that must be refused.
    for (int i = 0; i < MaxEntries - 3; i++) begin
      issue(CmdAppend, {$urandom, $urandom}, LenW'($urandom_range(0, 255)), 1'b0);
    end
    issue(CmdAppend, '1, '1, 1'b1);
    issue(CmdXfer, '1, '1, 1'b1);
    issue(CmdClear, '0, '0, 1'b0);
    issue(CmdAppend, 64'h8000_0000_0000_0000, 32'd100, 1'b0);
    issue(CmdXfer, '0, '1, 1'b1);

    // Well-formed lists with random content, mixed with noise and stale lists.
    while (issued < TargetItems) begin
      if ($urandom_range(0, 7) != 0) begin
        issue(CmdClear, {$urandom, $urandom}, $urandom, 1'($urandom_range(0, 1)));
      end
      n_append = $urandom_range(0, MaxEntries + 2);
      for (int i = 0; i < n_append; i++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          len = '0;
        end else if (pick == 1) begin
          len = '1;
        end else if (pick <= 3) begin
          len = $urandom;
        end else begin
          len = LenW'($urandom_range(1, 64));
        end
        issue(CmdAppend, {$urandom, $urandom}, len, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 19) == 0) begin
          issue(CmdW'($urandom), {$urandom, $urandom}, $urandom, 1'($urandom_range(0, 1)));
        end
      end
      n_xfer = $urandom_range(1, 4);
      for (int i = 0; i < n_xfer; i++) begin
        cap  = (listed_bytes > SizeW'(32'hFFFF_FFFF)) ? '1 : listed_bytes[LenW-1:0];
        pick = $urandom_range(0, 5);
        if (pick == 0) begin
          len = '0;
        end else if (pick == 1) begin
          len = '1;
        end else if (pick == 2) begin
          len = $urandom;
        end else if (pick == 3) begin
          len = cap;
        end else begin
          len = (cap == '0) ? '0 : LenW'($urandom_range(1, cap));
        end
        issue(CmdXfer, {$urandom, $urandom}, len, 1'($urandom_range(0, 1)));
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("scatter_gather_list_walker verification clean");
    end else begin
      $display("scatter_gather_list_walker verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("scatter_gather_list_walker verification failed");
    $finish;
  end

endmodule
